[rtl/cct_pkg.sv]
// ----------------------------------------------------------------------------
// cct_pkg
// Shared widths, register indexes and side-band types of the curvature and
// torsion unit.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Field formats of the item channels.
  localparam int IN_W   = 24;   // signed Q8.16 derivative components
  localparam int OUT_W  = 32;   // signed Q16.16 torsion
  localparam int K_W    = OUT_W - 1;  // unsigned Q15.16 curvature
  localparam int FRAC   = 16;

  // Configuration register widths.
  localparam int TTOL_W = 23;
  localparam int DTOL_W = 31;

  // APB port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes, taken from paddr[2].
  localparam logic REG_TAN_TOL = 1'b0;
  localparam logic REG_DEG_TOL = 1'b1;

  // Reset values of the registers.
  localparam logic [TTOL_W-1:0] TTOL_RST = TTOL_W'(66);
  localparam logic [DTOL_W-1:0] DTOL_RST = DTOL_W'(66);

  // Internal exact-arithmetic widths.
  localparam int DIG   = 24;          // digit width of the split multipliers
  localparam int P_W   = 2 * IN_W;    // product of two components
  localparam int SQ_W  = P_W - 1;     // square of a component
  localparam int C_W   = P_W + 1;     // cross product component
  localparam int N_W   = P_W;         // |t|^2
  localparam int S_W   = 96;          // |t x a|^2
  localparam int DET_W = 73;          // det(t, a, j), signed
  localparam int DAB_W = DET_W - 1;   // |det|
  localparam int D_W   = 144;         // |t|^6
  localparam int CQ_W  = 2 * K_W;     // curvature squared quotient

  // Result limits.
  localparam logic [K_W-1:0]   KMAX       = {K_W{1'b1}};
  localparam logic [OUT_W-1:0] TQ_POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] TQ_NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

  // Side band carried through the torsion divider.
  typedef struct packed {
    logic             end_mark;
    logic             czero;
    logic             sat_c;
    logic             tz;
    logic             sat_t;
    logic             neg;
    logic [S_W-1:0]   s;
    logic [D_W-1:0]   d;
  } tors_side_t;

  // Side band carried through the curvature divider and the square root.
  typedef struct packed {
    logic             end_mark;
    logic             czero;
    logic             sat_c;
    logic             tsat;
    logic [OUT_W-1:0] tq;
  } curv_side_t;

endpackage

[rtl/cct_in_if.sv]
// ----------------------------------------------------------------------------
// cct_in_if
// Input item channel: derivative vectors of one curve point and end mark.
// ----------------------------------------------------------------------------
interface cct_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [cct_pkg::IN_W-1:0]  tan_x;
  logic signed [cct_pkg::IN_W-1:0]  tan_y;
  logic signed [cct_pkg::IN_W-1:0]  tan_z;
  logic signed [cct_pkg::IN_W-1:0]  acc_x;
  logic signed [cct_pkg::IN_W-1:0]  acc_y;
  logic signed [cct_pkg::IN_W-1:0]  acc_z;
  logic signed [cct_pkg::IN_W-1:0]  jerk_x;
  logic signed [cct_pkg::IN_W-1:0]  jerk_y;
  logic signed [cct_pkg::IN_W-1:0]  jerk_z;
  logic                             end_of_curve;

  modport source (
    output valid, tan_x, tan_y, tan_z, acc_x, acc_y, acc_z,
           jerk_x, jerk_y, jerk_z, end_of_curve,
    input  ready
  );
  modport sink (
    input  valid, tan_x, tan_y, tan_z, acc_x, acc_y, acc_z,
           jerk_x, jerk_y, jerk_z, end_of_curve,
    output ready
  );
endinterface

[rtl/cct_out_if.sv]
// ----------------------------------------------------------------------------
// cct_out_if
// Result item channel: curvature, torsion, saturation flag and end mark.
// ----------------------------------------------------------------------------
interface cct_out_if;
  logic                             valid;
  logic                             ready;
  logic        [cct_pkg::K_W-1:0]   curvature;
  logic signed [cct_pkg::OUT_W-1:0] torsion;
  logic                             saturated;
  logic                             end_out;

  modport source (
    output valid, curvature, torsion, saturated, end_out,
    input  ready
  );
  modport sink (
    input  valid, curvature, torsion, saturated, end_out,
    output ready
  );
endinterface

[rtl/cct_div.sv]
// ----------------------------------------------------------------------------
// cct_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; zeros are shifted in below it.
// ----------------------------------------------------------------------------
module cct_div #(
  parameter int DEN_W = 96,
  parameter int Q_W   = 32,
  parameter int SB_W  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  side_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [SB_W-1:0]  side_o
);

  logic             valid_q [Q_W];
  logic [DEN_W-1:0] rem_q   [Q_W];
  logic [DEN_W-1:0] den_q   [Q_W];
  logic [Q_W-1:0]   quo_q   [Q_W];
  logic [SB_W-1:0]  side_q  [Q_W];

  logic             valid_in [Q_W];
  logic [DEN_W-1:0] rem_in   [Q_W];
  logic [DEN_W-1:0] den_in   [Q_W];
  logic [Q_W-1:0]   quo_in   [Q_W];
  logic [SB_W-1:0]  side_in  [Q_W];

  logic [DEN_W-1:0] rem_d [Q_W];
  logic [Q_W-1:0]   quo_d [Q_W];

  // Stage inputs: the ports feed the first stage, each stage feeds the next.
  always_comb begin
    valid_in[0] = valid_i;
    rem_in[0]   = rem_i;
    den_in[0]   = den_i;
    quo_in[0]   = '0;
    side_in[0]  = side_i;
    for (int s = 1; s < Q_W; s++) begin
      valid_in[s] = valid_q[s-1];
      rem_in[s]   = rem_q[s-1];
      den_in[s]   = den_q[s-1];
      quo_in[s]   = quo_q[s-1];
      side_in[s]  = side_q[s-1];
    end
  end

  // One shift, compare and conditional subtract per stage.
  always_comb begin
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           take;
    trial = '0;
    diff  = '0;
    take  = 1'b0;
    for (int s = 0; s < Q_W; s++) begin
      trial    = {rem_in[s], 1'b0};
      diff     = trial - {1'b0, den_in[s]};
      take     = trial >= {1'b0, den_in[s]};
      rem_d[s] = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d[s] = {quo_in[s][Q_W-2:0], take};
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Q_W; s++) valid_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < Q_W; s++) valid_q[s] <= valid_in[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Q_W; s++) begin
        rem_q[s]  <= rem_d[s];
        den_q[s]  <= den_in[s];
        quo_q[s]  <= quo_d[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

[rtl/cct_isqrt.sv]
// ----------------------------------------------------------------------------
// cct_isqrt
// Pipelined integer square root, one root bit per stage, rounding down.
// ----------------------------------------------------------------------------
module cct_isqrt #(
  parameter int R_W  = 31,
  parameter int SB_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*R_W-1:0]  val_i,
  input  logic [SB_W-1:0]   side_i,
  output logic              valid_o,
  output logic [R_W-1:0]    root_o,
  output logic [SB_W-1:0]   side_o
);

  localparam int V_W  = 2 * R_W;
  localparam int RM_W = R_W + 2;

  logic            valid_q [R_W];
  logic [RM_W-1:0] rem_q   [R_W];
  logic [R_W-1:0]  root_q  [R_W];
  logic [V_W-1:0]  val_q   [R_W];
  logic [SB_W-1:0] side_q  [R_W];

  logic            valid_in [R_W];
  logic [RM_W-1:0] rem_in   [R_W];
  logic [R_W-1:0]  root_in  [R_W];
  logic [V_W-1:0]  val_in   [R_W];
  logic [SB_W-1:0] side_in  [R_W];

  logic [RM_W-1:0] rem_d  [R_W];
  logic [R_W-1:0]  root_d [R_W];

  // Stage inputs.
  always_comb begin
    valid_in[0] = valid_i;
    rem_in[0]   = '0;
    root_in[0]  = '0;
    val_in[0]   = val_i;
    side_in[0]  = side_i;
    for (int s = 1; s < R_W; s++) begin
      valid_in[s] = valid_q[s-1];
      rem_in[s]   = rem_q[s-1];
      root_in[s]  = root_q[s-1];
      val_in[s]   = val_q[s-1];
      side_in[s]  = side_q[s-1];
    end
  end

  // Each stage brings down two bits and tries the next root bit.
  always_comb begin
    logic [RM_W+1:0] rr;
    logic [RM_W+1:0] trial;
    logic            take;
    rr    = '0;
    trial = '0;
    take  = 1'b0;
    for (int s = 0; s < R_W; s++) begin
      rr        = {rem_in[s], val_in[s][V_W-1-2*s -: 2]};
      trial     = (RM_W+2)'({root_in[s], 2'b01});
      take      = rr >= trial;
      rem_d[s]  = take ? RM_W'(rr - trial) : RM_W'(rr);
      root_d[s] = {root_in[s][R_W-2:0], take};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < R_W; s++) valid_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < R_W; s++) valid_q[s] <= valid_in[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < R_W; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        val_q[s]  <= val_in[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = valid_q[R_W-1];
  assign root_o  = root_q[R_W-1];
  assign side_o  = side_q[R_W-1];

endmodule

[rtl/curve_curvature_torsion_unit.sv]
// ----------------------------------------------------------------------------
// curve_curvature_torsion_unit
// Curvature and torsion of a space curve from its first three derivatives.
// ----------------------------------------------------------------------------
// The unit takes one curve point per clock while the output is not stalled
// and returns one result item per point, in order. The pipeline is made of
// an input register, six stages that form the cross product, the squared
// norms, the determinant and |t|^6 from 24 by 24 bit partial products, a
// 32-stage divider for the torsion, a 62-stage divider for the squared
// curvature, a 31-stage square root and the output register. All arithmetic
// is exact: curvature rounds down, torsion rounds toward zero, and both clip
// to their range with the saturated flag set. While the output holds an item
// that is not taken, the whole pipeline holds and no new point is taken. The
// user must write the tolerance registers through the APB port only while
// the unit is empty; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module curve_curvature_torsion_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  cct_in_if.sink                        pt_i,
  cct_out_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cct_pkg::PADDR_W-1:0]   paddr,
  input  logic [cct_pkg::PDATA_W-1:0]   pwdata,
  output logic [cct_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int IW    = cct_pkg::IN_W;
  localparam int DIG   = cct_pkg::DIG;
  localparam int P_W   = cct_pkg::P_W;
  localparam int SQ_W  = cct_pkg::SQ_W;
  localparam int C_W   = cct_pkg::C_W;
  localparam int N_W   = cct_pkg::N_W;
  localparam int S_W   = cct_pkg::S_W;
  localparam int DET_W = cct_pkg::DET_W;
  localparam int DAB_W = cct_pkg::DAB_W;
  localparam int D_W   = cct_pkg::D_W;
  localparam int OW    = cct_pkg::OUT_W;
  localparam int K_W   = cct_pkg::K_W;
  localparam int CQ_W_L = cct_pkg::CQ_W;
  localparam int TSB_W = $bits(cct_pkg::tors_side_t);
  localparam int CSB_W = $bits(cct_pkg::curv_side_t);

  // Pipeline advance: everything moves unless a result waits untaken.
  logic en;
  logic res_valid_q;
  assign en         = !res_valid_q || res_o.ready;
  assign pt_i.ready = en;

  // --------------------------------------------------------------------------
  // Configuration registers.
  // --------------------------------------------------------------------------
  logic [cct_pkg::TTOL_W-1:0] tan_tol_q;
  logic [cct_pkg::DTOL_W-1:0] deg_tol_q;
  logic                       reg_idx;

  assign reg_idx = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tan_tol_q <= cct_pkg::TTOL_RST;
      deg_tol_q <= cct_pkg::DTOL_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        cct_pkg::REG_TAN_TOL: tan_tol_q <= pwdata[cct_pkg::TTOL_W-1:0];
        cct_pkg::REG_DEG_TOL: deg_tol_q <= pwdata[cct_pkg::DTOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cct_pkg::REG_TAN_TOL: prdata = cct_pkg::PDATA_W'(tan_tol_q);
      cct_pkg::REG_DEG_TOL: prdata = cct_pkg::PDATA_W'(deg_tol_q);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage A: input register.
  // --------------------------------------------------------------------------
  logic                 a_valid_q;
  logic signed [IW-1:0] a_t_q [3];
  logic signed [IW-1:0] a_a_q [3];
  logic signed [IW-1:0] a_j_q [3];
  logic                 a_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else if (en) a_valid_q <= pt_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_t_q[0] <= pt_i.tan_x;
      a_t_q[1] <= pt_i.tan_y;
      a_t_q[2] <= pt_i.tan_z;
      a_a_q[0] <= pt_i.acc_x;
      a_a_q[1] <= pt_i.acc_y;
      a_a_q[2] <= pt_i.acc_z;
      a_j_q[0] <= pt_i.jerk_x;
      a_j_q[1] <= pt_i.jerk_y;
      a_j_q[2] <= pt_i.jerk_z;
      a_end_q  <= pt_i.end_of_curve;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: cross product terms, tangent squares, small-tangent test.
  // --------------------------------------------------------------------------
  logic                  b_valid_q;
  logic signed [P_W-1:0] b_p_q  [6];
  logic        [SQ_W-1:0] b_sq_q [3];
  logic signed [IW-1:0]  b_j_q  [3];
  logic                  b_small_q;
  logic                  b_end_q;

  logic signed [P_W-1:0] b_p_d  [6];
  logic        [SQ_W-1:0] b_sq_d [3];
  logic                  b_small_d;

  always_comb begin
    logic signed [P_W-1:0] sq;
    logic        [IW-1:0]  mag;
    sq  = '0;
    mag = '0;
    b_p_d[0]  = a_t_q[1] * a_a_q[2];
    b_p_d[1]  = a_t_q[2] * a_a_q[1];
    b_p_d[2]  = a_t_q[2] * a_a_q[0];
    b_p_d[3]  = a_t_q[0] * a_a_q[2];
    b_p_d[4]  = a_t_q[0] * a_a_q[1];
    b_p_d[5]  = a_t_q[1] * a_a_q[0];
    b_small_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      sq        = a_t_q[i] * a_t_q[i];
      b_sq_d[i] = sq[SQ_W-1:0];
      mag       = a_t_q[i][IW-1] ? (~a_t_q[i] + 1'b1) : a_t_q[i];
      if (!(mag < IW'(tan_tol_q))) b_small_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_valid_q <= 1'b0;
    else if (en) b_valid_q <= a_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_p_q     <= b_p_d;
      b_sq_q    <= b_sq_d;
      b_j_q     <= a_j_q;
      b_small_q <= b_small_d;
      b_end_q   <= a_end_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: cross product c = t x a and |t|^2.
  // --------------------------------------------------------------------------
  logic                  c_valid_q;
  logic signed [C_W-1:0] c_c_q [3];
  logic        [N_W-1:0] c_n_q;
  logic signed [IW-1:0]  c_j_q [3];
  logic                  c_small_q;
  logic                  c_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_valid_q <= 1'b0;
    else if (en) c_valid_q <= b_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_c_q[0]  <= C_W'(b_p_q[0]) - C_W'(b_p_q[1]);
      c_c_q[1]  <= C_W'(b_p_q[2]) - C_W'(b_p_q[3]);
      c_c_q[2]  <= C_W'(b_p_q[4]) - C_W'(b_p_q[5]);
      c_n_q     <= N_W'(b_sq_q[0]) + N_W'(b_sq_q[1]) + N_W'(b_sq_q[2]);
      c_j_q     <= b_j_q;
      c_small_q <= b_small_q;
      c_end_q   <= b_end_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: 24-bit digit partial products of c^2, c*j and N^2.
  // --------------------------------------------------------------------------
  logic                      d_valid_q;
  logic        [2*DIG-1:0]   d_hh_q [3];
  logic        [2*DIG-1:0]   d_hl_q [3];
  logic        [2*DIG-1:0]   d_ll_q [3];
  logic signed [C_W-1:0]     d_jh_q [3];
  logic signed [C_W-1:0]     d_jl_q [3];
  logic        [2*DIG-1:0]   d_nhh_q;
  logic        [2*DIG-1:0]   d_nhl_q;
  logic        [2*DIG-1:0]   d_nll_q;
  logic        [N_W-1:0]     d_n_q;
  logic                      d_small_q;
  logic                      d_end_q;

  logic        [2*DIG-1:0]   d_hh_d [3];
  logic        [2*DIG-1:0]   d_hl_d [3];
  logic        [2*DIG-1:0]   d_ll_d [3];
  logic signed [C_W-1:0]     d_jh_d [3];
  logic signed [C_W-1:0]     d_jl_d [3];

  always_comb begin
    logic [C_W-1:0] cabs;
    logic [DIG-1:0] ch;
    logic [DIG-1:0] cl;
    cabs = '0;
    ch   = '0;
    cl   = '0;
    for (int i = 0; i < 3; i++) begin
      cabs      = c_c_q[i][C_W-1] ? C_W'(-c_c_q[i]) : C_W'(c_c_q[i]);
      ch        = cabs[2*DIG-1:DIG];
      cl        = cabs[DIG-1:0];
      d_hh_d[i] = ch * ch;
      d_hl_d[i] = ch * cl;
      d_ll_d[i] = cl * cl;
      d_jh_d[i] = $signed(c_c_q[i][C_W-1:DIG]) * c_j_q[i];
      d_jl_d[i] = $signed({1'b0, c_c_q[i][DIG-1:0]}) * c_j_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_valid_q <= 1'b0;
    else if (en) d_valid_q <= c_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_hh_q    <= d_hh_d;
      d_hl_q    <= d_hl_d;
      d_ll_q    <= d_ll_d;
      d_jh_q    <= d_jh_d;
      d_jl_q    <= d_jl_d;
      d_nhh_q   <= c_n_q[2*DIG-1:DIG] * c_n_q[2*DIG-1:DIG];
      d_nhl_q   <= c_n_q[2*DIG-1:DIG] * c_n_q[DIG-1:0];
      d_nll_q   <= c_n_q[DIG-1:0] * c_n_q[DIG-1:0];
      d_n_q     <= c_n_q;
      d_small_q <= c_small_q;
      d_end_q   <= c_end_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: S = |c|^2, det = c . j and N^2 from the partial products.
  // --------------------------------------------------------------------------
  logic                    e_valid_q;
  logic        [S_W-1:0]   e_s_q;
  logic signed [DET_W-1:0] e_det_q;
  logic        [S_W-1:0]   e_n2_q;
  logic        [N_W-1:0]   e_n_q;
  logic                    e_czero_q;
  logic                    e_end_q;

  logic        [S_W-1:0]   e_s_d;
  logic signed [DET_W-1:0] e_det_d;

  always_comb begin
    e_s_d   = '0;
    e_det_d = '0;
    for (int i = 0; i < 3; i++) begin
      e_s_d   = e_s_d + (S_W'(d_hh_q[i]) << (2*DIG)) + (S_W'(d_hl_q[i]) << (DIG+1))
              + S_W'(d_ll_q[i]);
      e_det_d = e_det_d + (DET_W'(d_jh_q[i]) <<< DIG) + DET_W'(d_jl_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_valid_q <= 1'b0;
    else if (en) e_valid_q <= d_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_s_q     <= e_s_d;
      e_det_q   <= e_det_d;
      e_n2_q    <= (S_W'(d_nhh_q) << (2*DIG)) + (S_W'(d_nhl_q) << (DIG+1))
                 + S_W'(d_nll_q);
      e_n_q     <= d_n_q;
      e_czero_q <= d_small_q || (d_n_q == '0);
      e_end_q   <= d_end_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: partial products of N^3, torsion sign, magnitude and checks.
  // --------------------------------------------------------------------------
  logic               f_valid_q;
  logic [2*DIG-1:0]   f_pp_q [8];
  logic [S_W-1:0]     f_s_q;
  logic [DAB_W-1:0]   f_dabs_q;
  logic               f_neg_q;
  logic               f_tz_q;
  logic               f_sat_t_q;
  logic               f_czero_q;
  logic               f_end_q;

  logic [2*DIG-1:0]   f_pp_d [8];
  logic [DAB_W-1:0]   f_dabs_d;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int m = 0; m < 2; m++) begin
        f_pp_d[2*k+m] = e_n2_q[k*DIG +: DIG] * e_n_q[m*DIG +: DIG];
      end
    end
    f_dabs_d = e_det_q[DET_W-1] ? DAB_W'(-e_det_q) : DAB_W'(e_det_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_valid_q <= 1'b0;
    else if (en) f_valid_q <= e_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_pp_q    <= f_pp_d;
      f_s_q     <= e_s_q;
      f_dabs_q  <= f_dabs_d;
      f_neg_q   <= e_det_q[DET_W-1];
      f_tz_q    <= (e_s_q == '0) || (e_s_q < (S_W'(deg_tol_q) << (3*cct_pkg::FRAC)));
      f_sat_t_q <= e_s_q <= S_W'(f_dabs_d);
      f_czero_q <= e_czero_q;
      f_end_q   <= e_end_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage G: D = N^3.
  // --------------------------------------------------------------------------
  logic               g_valid_q;
  logic [D_W-1:0]     g_d_q;
  logic [S_W-1:0]     g_s_q;
  logic [DAB_W-1:0]   g_dabs_q;
  logic               g_neg_q;
  logic               g_tz_q;
  logic               g_sat_t_q;
  logic               g_czero_q;
  logic               g_end_q;

  logic [D_W-1:0]     g_d_d;

  always_comb begin
    g_d_d = '0;
    for (int k = 0; k < 4; k++) begin
      for (int m = 0; m < 2; m++) begin
        g_d_d = g_d_d + (D_W'(f_pp_q[2*k+m]) << (DIG*(k+m)));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_valid_q <= 1'b0;
    else if (en) g_valid_q <= f_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_d_q     <= g_d_d;
      g_s_q     <= f_s_q;
      g_dabs_q  <= f_dabs_q;
      g_neg_q   <= f_neg_q;
      g_tz_q    <= f_tz_q;
      g_sat_t_q <= f_sat_t_q;
      g_czero_q <= f_czero_q;
      g_end_q   <= f_end_q;
    end
  end

  // --------------------------------------------------------------------------
  // Torsion divider: |det| * 2^32 / S. Curvature saturates when 4*S >= D.
  // --------------------------------------------------------------------------
  cct_pkg::tors_side_t tside_in;
  cct_pkg::tors_side_t tside_out;
  logic [TSB_W-1:0]    tside_vec;
  logic                t_valid;
  logic [OW-1:0]       t_quo;

  always_comb begin
    tside_in.end_mark = g_end_q;
    tside_in.czero    = g_czero_q;
    tside_in.sat_c    = (D_W'(g_s_q) << 2) >= g_d_q;
    tside_in.tz       = g_tz_q;
    tside_in.sat_t    = g_sat_t_q;
    tside_in.neg      = g_neg_q;
    tside_in.s        = g_s_q;
    tside_in.d        = g_d_q;
  end

  cct_div #(
    .DEN_W (S_W),
    .Q_W   (OW),
    .SB_W  (TSB_W)
  ) u_tors_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_valid_q),
    .rem_i   (S_W'(g_dabs_q)),
    .den_i   (g_s_q),
    .side_i  (tside_in),
    .valid_o (t_valid),
    .quo_o   (t_quo),
    .side_o  (tside_vec)
  );

  assign tside_out = tside_vec;

  // Torsion clipping and sign.
  cct_pkg::curv_side_t cside_in;
  logic [OW-1:0]       t_lim;
  logic                t_over;
  logic [OW-1:0]       t_mag;

  always_comb begin
    t_lim  = tside_out.neg ? cct_pkg::TQ_NEG_LIM : cct_pkg::TQ_POS_LIM;
    t_over = t_quo > t_lim;
    t_mag  = (tside_out.sat_t || t_over) ? t_lim : t_quo;
    cside_in.end_mark = tside_out.end_mark;
    cside_in.czero    = tside_out.czero;
    cside_in.sat_c    = tside_out.sat_c;
    cside_in.tsat     = !tside_out.tz && (tside_out.sat_t || t_over);
    if (tside_out.tz) begin
      cside_in.tq = '0;
    end else if (tside_out.neg) begin
      cside_in.tq = ~t_mag + 1'b1;
    end else begin
      cside_in.tq = t_mag;
    end
  end

  // --------------------------------------------------------------------------
  // Curvature divider: S * 2^64 / D, then the square root of the quotient.
  // --------------------------------------------------------------------------
  logic [CSB_W-1:0]     cdiv_side;
  logic                 c_dvalid;
  logic [CQ_W_L-1:0]    c_quo;

  cct_div #(
    .DEN_W (D_W),
    .Q_W   (CQ_W_L),
    .SB_W  (CSB_W)
  ) u_curv_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t_valid),
    .rem_i   (D_W'({tside_out.s, 2'b00})),
    .den_i   (tside_out.d),
    .side_i  (cside_in),
    .valid_o (c_dvalid),
    .quo_o   (c_quo),
    .side_o  (cdiv_side)
  );

  logic [CSB_W-1:0]    sq_side_vec;
  cct_pkg::curv_side_t sq_side;
  logic                sq_valid;
  logic [K_W-1:0]      sq_root;

  cct_isqrt #(
    .R_W  (K_W),
    .SB_W (CSB_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_dvalid),
    .val_i   (c_quo),
    .side_i  (cdiv_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side_vec)
  );

  assign sq_side = sq_side_vec;

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  logic [K_W-1:0] res_curv_q;
  logic [OW-1:0]  res_tors_q;
  logic           res_sat_q;
  logic           res_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_valid_q <= 1'b0;
    else if (en) res_valid_q <= sq_valid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sq_side.czero) begin
        res_curv_q <= '0;
      end else if (sq_side.sat_c) begin
        res_curv_q <= cct_pkg::KMAX;
      end else begin
        res_curv_q <= sq_root;
      end
      res_tors_q <= sq_side.tq;
      res_sat_q  <= (!sq_side.czero && sq_side.sat_c) || sq_side.tsat;
      res_end_q  <= sq_side.end_mark;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.curvature = res_curv_q;
  assign res_o.torsion   = res_tors_q;
  assign res_o.saturated = res_sat_q;
  assign res_o.end_out   = res_end_q;

endmodule

[rtl/cct_checker.sv]
// ----------------------------------------------------------------------------
// cct_checker
// Port-level checks of the curvature and torsion unit's flow control.
// ----------------------------------------------------------------------------
module cct_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [cct_pkg::K_W-1:0]       out_curv_i,
  input logic [cct_pkg::OUT_W-1:0]     out_tors_i,
  input logic                          out_sat_i,
  input logic                          out_end_i
);

  // A result that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_curv_i) &&
      $stable(out_tors_i) && $stable(out_sat_i) && $stable(out_end_i))
    else $error("result changed while stalled");

  // The unit only refuses an item while a result waits untaken.
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output backpressure");

  // Taking a result always frees the pipeline for a new item.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |-> in_ready_i)
    else $error("input not ready while result taken");

  // No item is refused while the output is idle.
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && in_valid_i |-> in_ready_i)
    else $error("item refused with empty output");

endmodule

bind curve_curvature_torsion_unit cct_checker u_cct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_i.valid),
  .in_ready_i  (pt_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_curv_i  (res_o.curvature),
  .out_tors_i  (res_o.torsion),
  .out_sat_i   (res_o.saturated),
  .out_end_i   (res_o.end_out)
);

[tb/curve_curvature_torsion_unit_test.sv]
// ----------------------------------------------------------------------------
// Curvature and torsion unit testbench
// Sends curve points through the item channels and checks every result
// against an exact integer predictor. The tolerance registers are changed
// over several phases. Random stalls fall on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module curve_curvature_torsion_unit_test;

  localparam int IN_W    = cct_pkg::IN_W;
  localparam int OUT_W   = cct_pkg::OUT_W;
  localparam int K_W     = cct_pkg::K_W;
  localparam int FRAC    = cct_pkg::FRAC;
  localparam int TTOL_W  = cct_pkg::TTOL_W;
  localparam int DTOL_W  = cct_pkg::DTOL_W;
  localparam int PADDR_W = cct_pkg::PADDR_W;
  localparam int PDATA_W = cct_pkg::PDATA_W;

  // One curve point and one curvature/torsion result.
  typedef struct {
    logic signed [IN_W-1:0] tng[3];
    logic signed [IN_W-1:0] acc[3];
    logic signed [IN_W-1:0] jrk[3];
    logic                   eoc;
  } point_t;

  typedef struct {
    logic [K_W-1:0]   curvature;
    logic [OUT_W-1:0] torsion;
    logic             saturated;
    logic             end_out;
  } frenet_t;

  // Scoreboard: predicts each result and compares it with what comes out.
  class frenet_board;
    logic [TTOL_W-1:0] tan_tol = cct_pkg::TTOL_RST;
    logic [DTOL_W-1:0] deg_tol = cct_pkg::DTOL_RST;
    frenet_t           expected_q[$];
    int                errors = 0;

    function void set_tolerance(logic idx, logic [PDATA_W-1:0] val);
      if (idx == cct_pkg::REG_TAN_TOL) tan_tol = val[TTOL_W-1:0];
      else deg_tol = val[DTOL_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Exact curvature and torsion of one point.
    function frenet_t frenet_of(point_t p);
      logic signed [127:0] t[3], a[3], j[3], c[3], tm[3], cm, detv, dm;
      logic [255:0]        s, n, x, d, y, q, lim, cand, curv;
      frenet_t             r;
      logic                small_tan;
      s = 0;
      n = 0;
      detv = 0;
      curv = 0;
      q = 0;
      r.saturated = 1'b0;
      r.end_out = p.eoc;
      for (int i = 0; i < 3; i++) begin
        t[i] = p.tng[i];
        a[i] = p.acc[i];
        j[i] = p.jrk[i];
      end
      c[0] = t[1] * a[2] - t[2] * a[1];
      c[1] = t[2] * a[0] - t[0] * a[2];
      c[2] = t[0] * a[1] - t[1] * a[0];
      for (int i = 0; i < 3; i++) begin
        tm[i] = (t[i] < 0) ? -t[i] : t[i];
        cm = (c[i] < 0) ? -c[i] : c[i];
        s = s + {128'b0, cm} * {128'b0, cm};
        n = n + {128'b0, tm[i]} * {128'b0, tm[i]};
        detv = detv + c[i] * j[i];
      end
      small_tan = tm[0] < tan_tol && tm[1] < tan_tol && tm[2] < tan_tol;

      // Curvature: largest k with k^2 * |t|^6 <= |t x a|^2 * 2^64.
      if (!small_tan && n != 0) begin
        x = s << 64;
        d = n * n * n;
        if ((d << (2 * K_W)) <= x) begin
          curv = {225'b0, cct_pkg::KMAX};
          r.saturated = 1'b1;
        end else begin
          for (int b = K_W - 1; b >= 0; b--) begin
            cand = curv | (256'd1 << b);
            if (cand * cand * d <= x) curv = cand;
          end
        end
      end
      r.curvature = curv[K_W-1:0];

      // Torsion: det * 2^32 / |t x a|^2, truncated toward zero.
      r.torsion = '0;
      if (s != 0 && s >= ({225'b0, deg_tol} << (3 * FRAC))) begin
        dm = (detv < 0) ? -detv : detv;
        y = {128'b0, dm} << (2 * FRAC);
        lim = (detv < 0) ? (256'd1 << (OUT_W - 1)) : ((256'd1 << (OUT_W - 1)) - 1);
        if ((s << OUT_W) <= y) begin
          q = lim;
          r.saturated = 1'b1;
        end else begin
          q = y / s;
          if (q > lim) begin
            q = lim;
            r.saturated = 1'b1;
          end
        end
        r.torsion = (detv < 0) ? -q[OUT_W-1:0] : q[OUT_W-1:0];
      end
      return r;
    endfunction

    function void note_point(point_t p);
      expected_q.insert(expected_q.size(), frenet_of(p));
    endfunction

    function void check_result(frenet_t got);
      frenet_t w;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: k=%h tau=%h", $time,
                 got.curvature, got.torsion);
        errors++;
        return;
      end
      w = expected_q.pop_front();
      if (got.curvature !== w.curvature) begin
        $display("%0t: curvature expected %h actual %h", $time, w.curvature,
                 got.curvature);
        errors++;
      end
      if (got.torsion !== w.torsion) begin
        $display("%0t: torsion expected %h actual %h", $time, w.torsion, got.torsion);
        errors++;
      end
      if (got.saturated !== w.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, w.saturated,
                 got.saturated);
        errors++;
      end
      if (got.end_out !== w.end_out) begin
        $display("%0t: end_out expected %b actual %b", $time, w.end_out, got.end_out);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               quiet;

  cct_in_if  pt_if ();
  cct_out_if res_if ();

  frenet_board board = new();

  curve_curvature_torsion_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pt_i    (pt_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("curve_curvature_torsion_unit_test NOT OK");
    $finish;
  end

  // Result side: ready drops in random bursts unless the run is quiet.
  initial begin
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // Monitor: notes accepted points and checks accepted results.
  always @(posedge clk_i) begin
    point_t  p;
    frenet_t r;
    if (rst_ni) begin
      if (pt_if.valid && pt_if.ready) begin
        p.tng[0] = pt_if.tan_x;
        p.tng[1] = pt_if.tan_y;
        p.tng[2] = pt_if.tan_z;
        p.acc[0] = pt_if.acc_x;
        p.acc[1] = pt_if.acc_y;
        p.acc[2] = pt_if.acc_z;
        p.jrk[0] = pt_if.jerk_x;
        p.jrk[1] = pt_if.jerk_y;
        p.jrk[2] = pt_if.jerk_z;
        p.eoc    = pt_if.end_of_curve;
        board.note_point(p);
      end
      if (res_if.valid && res_if.ready) begin
        r.curvature = res_if.curvature;
        r.torsion   = res_if.torsion;
        r.saturated = res_if.saturated;
        r.end_out   = res_if.end_out;
        board.check_result(r);
      end
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic write_tolerance(logic idx, logic [PDATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_tolerance(idx, val);
    @(posedge clk_i);
  endtask

  // Offer one point and hold it until taken, then maybe leave a gap.
  task automatic send_point(point_t p);
    pt_if.valid        <= 1'b1;
    pt_if.tan_x        <= p.tng[0];
    pt_if.tan_y        <= p.tng[1];
    pt_if.tan_z        <= p.tng[2];
    pt_if.acc_x        <= p.acc[0];
    pt_if.acc_y        <= p.acc[1];
    pt_if.acc_z        <= p.acc[2];
    pt_if.jerk_x       <= p.jrk[0];
    pt_if.jerk_y       <= p.jrk[1];
    pt_if.jerk_z       <= p.jrk[2];
    pt_if.end_of_curve <= p.eoc;
    @(posedge clk_i);
    while (!pt_if.ready) @(posedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      pt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Wait until every result is back and the pipeline is empty.
  task automatic drain();
    pt_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // Random component of a random magnitude range.
  function automatic logic signed [IN_W-1:0] rand_comp(int bits);
    logic signed [IN_W-1:0] v;
    v = IN_W'($urandom);
    return v >>> (IN_W - bits);
  endfunction

  function automatic point_t rand_point();
    point_t p;
    int     kind, bt, ba, bj;
    kind = $urandom_range(0, 9);
    bt = $urandom_range(1, IN_W);
    ba = $urandom_range(1, IN_W);
    bj = $urandom_range(1, IN_W);
    if (kind < 2) begin
      bt = IN_W;
      ba = IN_W;
      bj = IN_W;
    end
    for (int i = 0; i < 3; i++) begin
      p.tng[i] = rand_comp(bt);
      p.acc[i] = rand_comp(ba);
      p.jrk[i] = rand_comp(bj);
    end
    // Nearly parallel derivatives give a degenerate osculating plane.
    if (kind == 2) begin
      for (int i = 0; i < 3; i++)
        p.acc[i] = (p.tng[i] >>> $urandom_range(0, 3)) + rand_comp(2);
    end
    // Tangent close to the tolerance.
    if (kind == 3) begin
      for (int i = 0; i < 3; i++)
        p.tng[i] = rand_comp($urandom_range(1, 9));
    end
    p.eoc = ($urandom_range(0, 15) == 0);
    return p;
  endfunction

  function automatic point_t make_point(int tx, int ty, int tz, int ax, int ay, int az,
                                        int jx, int jy, int jz, logic e);
    point_t p;
    p.tng[0] = IN_W'(tx); p.tng[1] = IN_W'(ty); p.tng[2] = IN_W'(tz);
    p.acc[0] = IN_W'(ax); p.acc[1] = IN_W'(ay); p.acc[2] = IN_W'(az);
    p.jrk[0] = IN_W'(jx); p.jrk[1] = IN_W'(jy); p.jrk[2] = IN_W'(jz);
    p.eoc = e;
    return p;
  endfunction

  // Points worth sending under every setting of the tolerances.
  task automatic send_corners();
    int mx, mn, one;
    mx  = 8388607;
    mn  = -8388608;
    one = 1 << FRAC;
    send_point(make_point(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
    send_point(make_point(0, 0, 0, one, one, 0, 0, 0, one, 1'b1));
    send_point(make_point(mx, mx, mx, mx, mx, mx, mx, mx, mx, 1'b0));
    send_point(make_point(mn, mn, mn, mn, mn, mn, mn, mn, mn, 1'b1));
    send_point(make_point(mx, mn, mx, mn, mx, mn, mx, mn, mx, 1'b0));
    send_point(make_point(mx, 0, 0, 0, mn, 0, 0, 0, mx, 1'b0));
    send_point(make_point(mn, 0, 0, 0, mx, 0, 0, 0, mn, 1'b1));
  endtask

  task automatic send_directed();
    int one;
    one = 1 << FRAC;
    // Helix-like unit frame: curvature one, torsion plus and minus one.
    send_point(make_point(one, 0, 0, 0, one, 0, 0, 0, one, 1'b0));
    send_point(make_point(one, 0, 0, 0, one, 0, 0, 0, -one, 1'b0));
    // Tangent just below and at the tangent tolerance.
    send_point(make_point(65, -65, 0, one, 0, one, 0, one, 0, 1'b0));
    send_point(make_point(66, 0, 0, 0, one, 0, 0, 0, one, 1'b0));
    // Parallel derivatives: flat, no torsion.
    send_point(make_point(one, 2 * one, -one, 2 * one, 4 * one, -2 * one, 5, 7, 9, 1'b0));
    // Tiny cross product below the degeneracy tolerance.
    send_point(make_point(one, 0, 0, 0, 1, 0, 0, 0, one, 1'b0));
    // Small cross product with a large jerk, below the degeneracy tolerance.
    send_point(make_point(one, 0, 0, 0, 256, 0, 0, 0, 8388607, 1'b0));
    send_point(make_point(one, 0, 0, 0, 256, 0, 0, 0, -8388608, 1'b1));
    // Slow tangent, large acceleration: curvature clips.
    send_point(make_point(100, 0, 0, 0, 8388607, 0, 0, 0, one, 1'b0));
    send_corners();
  endtask

  task automatic send_random(int count);
    repeat (count) send_point(rand_point());
  endtask

  // Stimulus and end of run.
  initial begin
    quiet          = 1'b0;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    pt_if.valid    <= 1'b0;
    pt_if.tan_x    <= '0;
    pt_if.tan_y    <= '0;
    pt_if.tan_z    <= '0;
    pt_if.acc_x    <= '0;
    pt_if.acc_y    <= '0;
    pt_if.acc_z    <= '0;
    pt_if.jerk_x   <= '0;
    pt_if.jerk_y   <= '0;
    pt_if.jerk_z   <= '0;
    pt_if.end_of_curve <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset tolerances.
    send_directed();
    send_random(220);
    drain();

    // Zero tolerances: an exactly zero tangent reaches the divider guards.
    write_tolerance(cct_pkg::REG_TAN_TOL, 32'h0);
    write_tolerance(cct_pkg::REG_DEG_TOL, 32'h0);
    send_corners();
    send_random(220);
    drain();

    // Largest tolerances, written with stray upper bits.
    write_tolerance(cct_pkg::REG_TAN_TOL, 32'hFF80_0000 | 32'h7F_FFFF);
    write_tolerance(cct_pkg::REG_DEG_TOL, 32'hFFFF_FFFF);
    send_corners();
    send_random(220);
    drain();

    // Random tolerances.
    write_tolerance(cct_pkg::REG_TAN_TOL, $urandom_range(0, 1 << 14));
    write_tolerance(cct_pkg::REG_DEG_TOL, $urandom_range(0, 1 << 20));
    send_random(220);
    drain();

    // Final phase runs without any idling.
    write_tolerance(cct_pkg::REG_TAN_TOL, 32'h1_0000);
    write_tolerance(cct_pkg::REG_DEG_TOL, 32'h1_0000);
    quiet = 1'b1;
    send_corners();
    send_random(220);
    drain();

    if (board.errors == 0 && board.pending() == 0) begin
      $display("curve_curvature_torsion_unit_test OK");
    end else begin
      $display("curve_curvature_torsion_unit_test NOT OK");
    end
    $finish;
  end

endmodule
